### design/symmetric_coincidence_matrix_macros.svh
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix assertion macros
// Concurrent assertion wrappers. The enabled forms are compiled in simulation
// and left out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_COINCIDENCE_MATRIX_MACROS_SVH
`define SYMMETRIC_COINCIDENCE_MATRIX_MACROS_SVH
`ifndef SYNTH
`define SCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scm: same-cycle assertion failed");
`define SCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scm: next-cycle assertion failed");
`else
`define SCM_ASSERT_NOW(label, ante, cons)
`define SCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/scm_pkg.sv
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix package
// Shared constants, types and helper functions of the coincidence matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    localparam int CHANNELS   = 4096;
    localparam int MAX_MULT   = 40;
    localparam int CH_W       = 12;
    localparam int COUNT_W    = 32;
    localparam int CELL_TOTAL = CHANNELS * (CHANNELS + 1) / 2;
    localparam int ADDR_W     = $clog2(CELL_TOTAL);
    localparam int HIT_IDX_W  = $clog2(MAX_MULT);
    localparam int HIT_CNT_W  = $clog2(MAX_MULT + 1);
    localparam int PROD_W     = 2 * CH_W + 1;
    localparam int OUT_DEPTH  = 2;
    localparam int PEND_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_ACCEPT,
        ST_ISSUE
    } state_t;

    typedef enum logic {
        KIND_HIT  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } result_t;

    function automatic logic channel_valid(input logic [CH_W-1:0] ch);
        return (int'(ch) >= 1) && (int'(ch) <= CHANNELS - 2);
    endfunction

endpackage

`default_nettype wire

### design/symmetric_coincidence_matrix.sv
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix
// Two-fold coincidence histogram kept as a lower triangle in one memory.
// The input channel takes one request per item: kind 0 is an event hit with
// its channel and a last_hit flag, kind 1 reads the cell at row and column.
// A hit request gives no result; a read request gives one cell_count on the
// output channel. A read result passes the p1, p2 and p3 pipeline registers
// and the output queue before it shows on out_valid. Two reads may be taken
// back to back; in_stall then holds the input until the first result leaves.
// A hit request whose channel is valid while n earlier hits are stored in the
// event (n from 1 to 39) holds the block in ST_ISSUE while its n pairs are
// issued, one count memory read-modify-write per pair issued each cycle;
// in_stall stays high meanwhile. Any other hit request starts no pairs.
// After reset the count memory is cleared one cell per cycle, all 8390656
// cells; in_stall stays high during that pass.
// A two-entry output queue holds results while out_stall is high; in_stall
// rises once two read results are outstanding, so no result is ever lost.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_coincidence_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [scm_pkg::CH_W-1:0]      channel,
    input  logic [scm_pkg::CH_W-1:0]      read_column,
    input  logic                          last_hit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scm_pkg::COUNT_W-1:0]   cell_count
);

    import scm_pkg::*;

    logic                 out_take;
    logic                 hit_we;
    logic [HIT_IDX_W-1:0] hit_waddr;
    logic [CH_W-1:0]      hit_wdata;
    logic [HIT_IDX_W-1:0] hit_raddr;
    logic [CH_W-1:0]      hit_rdata;
    logic                 cnt_we;
    logic [ADDR_W-1:0]    cnt_waddr;
    logic [COUNT_W-1:0]   cnt_wdata;
    logic [ADDR_W-1:0]    cnt_raddr;
    logic [COUNT_W-1:0]   cnt_rdata;
    result_t              res;

    assign out_take = out_valid && !out_stall;

    scm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .channel     (channel),
        .read_column (read_column),
        .last_hit    (last_hit),
        .out_take    (out_take),
        .hit_we      (hit_we),
        .hit_waddr   (hit_waddr),
        .hit_wdata   (hit_wdata),
        .hit_raddr   (hit_raddr),
        .hit_rdata   (hit_rdata),
        .cnt_we      (cnt_we),
        .cnt_waddr   (cnt_waddr),
        .cnt_wdata   (cnt_wdata),
        .cnt_raddr   (cnt_raddr),
        .cnt_rdata   (cnt_rdata),
        .res         (res)
    );

    scm_ram #(
        .DEPTH (MAX_MULT),
        .WIDTH (CH_W)
    ) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (hit_raddr),
        .rdata (hit_rdata)
    );

    scm_ram #(
        .DEPTH (CELL_TOTAL),
        .WIDTH (COUNT_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    scm_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_count (cell_count)
    );

endmodule

`default_nettype wire

### design/scm_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

### design/scm_outq.sv
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix result queue
// Two-entry queue that holds read results while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scm_pkg::result_t              push,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scm_pkg::COUNT_W-1:0]   cell_count
);

    import scm_pkg::*;

    logic [PEND_W-1:0]  count_reg;
    logic [PEND_W-1:0]  count_next;
    logic [COUNT_W-1:0] slot0_reg;
    logic [COUNT_W-1:0] slot1_reg;
    logic               pop;

    assign out_valid  = (count_reg != '0);
    assign cell_count = slot0_reg;
    assign pop        = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + PEND_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= slot1_reg;
            if (push.valid && (count_reg == PEND_W'(1)))
            begin
                slot0_reg <= push.count;
            end
            if (push.valid && (count_reg == PEND_W'(OUT_DEPTH)))
            begin
                slot1_reg <= push.count;
            end
        end
        else if (push.valid)
        begin
            if (count_reg == '0)
            begin
                slot0_reg <= push.count;
            end
            else
            begin
                slot1_reg <= push.count;
            end
        end
    end

endmodule

`default_nettype wire

### design/scm_ctrl.sv
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix controller
// Sequences the clearing pass, the hit list and the read-modify-write
// pipeline on the count memory, with forwarding of the last write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "symmetric_coincidence_matrix_macros.svh"

module scm_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [scm_pkg::CH_W-1:0]        channel,
    input  logic [scm_pkg::CH_W-1:0]        read_column,
    input  logic                            last_hit,
    input  logic                            out_take,
    output logic                            hit_we,
    output logic [scm_pkg::HIT_IDX_W-1:0]   hit_waddr,
    output logic [scm_pkg::CH_W-1:0]        hit_wdata,
    output logic [scm_pkg::HIT_IDX_W-1:0]   hit_raddr,
    input  logic [scm_pkg::CH_W-1:0]        hit_rdata,
    output logic                            cnt_we,
    output logic [scm_pkg::ADDR_W-1:0]      cnt_waddr,
    output logic [scm_pkg::COUNT_W-1:0]     cnt_wdata,
    output logic [scm_pkg::ADDR_W-1:0]      cnt_raddr,
    input  logic [scm_pkg::COUNT_W-1:0]     cnt_rdata,
    output scm_pkg::result_t                res
);

    import scm_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [HIT_CNT_W-1:0] hit_count_reg;
    logic [HIT_IDX_W-1:0] issue_idx_reg;
    logic [HIT_CNT_W-1:0] issue_n_reg;
    logic [CH_W-1:0]      cur_ch_reg;
    logic [PEND_W-1:0]    pend_reg;

    logic                 p1_valid_reg;
    logic                 p1_read_reg;
    logic [CH_W-1:0]      p1_a_reg;
    logic [CH_W-1:0]      p1_b_reg;
    logic                 p2_valid_reg;
    logic                 p2_read_reg;
    logic [ADDR_W-1:0]    p2_base_reg;
    logic [CH_W-1:0]      p2_lo_reg;
    logic                 p3_valid_reg;
    logic                 p3_read_reg;
    logic [ADDR_W-1:0]    p3_addr_reg;
    logic                 wl_valid_reg;
    logic [ADDR_W-1:0]    wl_addr_reg;
    logic [COUNT_W-1:0]   wl_data_reg;

    logic                 accept;
    logic                 acc_read;
    logic                 acc_hit;
    logic                 hit_room;
    logic                 start_issue;
    logic                 issue_done;
    logic                 issuing;
    logic                 clearing;
    logic                 clear_done;
    logic [CH_W-1:0]      p1_b;
    logic                 p1_ok;
    logic [CH_W-1:0]      p1_hi;
    logic [CH_W-1:0]      p1_lo;
    logic [PROD_W-1:0]    p1_hi_ext;
    logic [PROD_W-1:0]    p1_prod;
    logic [ADDR_W-1:0]    p2_addr;
    logic [COUNT_W-1:0]   p3_cur;
    logic                 p3_write;

    assign accept      = in_valid && !in_stall;
    assign acc_read    = accept && (kind == KIND_READ);
    assign acc_hit     = accept && (kind == KIND_HIT);
    assign hit_room    = hit_count_reg < HIT_CNT_W'(MAX_MULT);
    assign start_issue = acc_hit && hit_room && (hit_count_reg != '0) && channel_valid(channel);
    assign issue_done  = (HIT_CNT_W'(issue_idx_reg) + HIT_CNT_W'(1)) == issue_n_reg;
    assign clear_done  = clr_addr_reg == ADDR_W'(CELL_TOTAL - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_ACCEPT:
            begin
                if (start_issue)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (issue_done)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        issuing  = 1'b0;
        clearing = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_ACCEPT:
            begin
                in_stall = (pend_reg == PEND_W'(OUT_DEPTH));
            end
            ST_ISSUE:
            begin
                issuing = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign hit_we    = acc_hit && hit_room;
    assign hit_waddr = hit_count_reg[HIT_IDX_W-1:0];
    assign hit_wdata = channel;
    assign hit_raddr = issue_idx_reg;

    always_comb
    begin
        p1_b      = p1_read_reg ? p1_b_reg : hit_rdata;
        p1_ok     = p1_valid_reg && (p1_read_reg || channel_valid(hit_rdata));
        p1_hi     = (p1_a_reg > p1_b) ? p1_a_reg : p1_b;
        p1_lo     = (p1_a_reg > p1_b) ? p1_b : p1_a_reg;
        p1_hi_ext = PROD_W'(p1_hi);
        p1_prod   = p1_hi_ext * (p1_hi_ext + PROD_W'(1));
    end

    assign p2_addr   = p2_base_reg + ADDR_W'(p2_lo_reg);
    assign cnt_raddr = p2_addr;

    assign p3_cur    = (wl_valid_reg && (wl_addr_reg == p3_addr_reg)) ? wl_data_reg : cnt_rdata;
    assign p3_write  = p3_valid_reg && !p3_read_reg;

    assign cnt_we    = clearing || p3_write;
    assign cnt_waddr = clearing ? clr_addr_reg : p3_addr_reg;
    assign cnt_wdata = clearing ? '0 : (p3_cur + COUNT_W'(1));

    assign res.valid = p3_valid_reg && p3_read_reg;
    assign res.count = p3_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            hit_count_reg <= '0;
            issue_idx_reg <= '0;
            pend_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            wl_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (acc_hit)
            begin
                if (last_hit)
                begin
                    hit_count_reg <= '0;
                end
                else if (hit_room)
                begin
                    hit_count_reg <= hit_count_reg + HIT_CNT_W'(1);
                end
            end
            if (start_issue)
            begin
                issue_idx_reg <= '0;
            end
            else if (issuing)
            begin
                issue_idx_reg <= issue_idx_reg + HIT_IDX_W'(1);
            end
            if (acc_read && !out_take)
            begin
                pend_reg <= pend_reg + PEND_W'(1);
            end
            else if (out_take && !acc_read)
            begin
                pend_reg <= pend_reg - PEND_W'(1);
            end
            p1_valid_reg <= issuing || acc_read;
            p2_valid_reg <= p1_ok;
            p3_valid_reg <= p2_valid_reg;
            wl_valid_reg <= p3_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_issue)
        begin
            issue_n_reg <= hit_count_reg;
            cur_ch_reg  <= channel;
        end
        p1_read_reg <= acc_read;
        p1_a_reg    <= acc_read ? channel : cur_ch_reg;
        p1_b_reg    <= read_column;
        p2_read_reg <= p1_read_reg;
        p2_base_reg <= ADDR_W'(p1_prod >> 1);
        p2_lo_reg   <= p1_lo;
        p3_read_reg <= p2_read_reg;
        p3_addr_reg <= p2_addr;
        wl_addr_reg <= p3_addr_reg;
        wl_data_reg <= cnt_wdata;
    end

    `SCM_ASSERT_NOW(a_hit_count_bound, 1'b1, hit_count_reg <= HIT_CNT_W'(MAX_MULT))
    `SCM_ASSERT_NOW(a_issue_in_range, state_reg == ST_ISSUE, HIT_CNT_W'(issue_idx_reg) < issue_n_reg)
    `SCM_ASSERT_NOW(a_no_update_in_clear, p3_write, state_reg != ST_CLEAR)
    `SCM_ASSERT_NOW(a_result_reserved, res.valid, pend_reg != '0)
    `SCM_ASSERT_NEXT(a_last_ends_event, acc_hit && last_hit, hit_count_reg == '0)

endmodule

`default_nettype wire

### sim/symmetric_coincidence_matrix_tb.sv
// ----------------------------------------------------------------------------
// Symmetric coincidence matrix testbench
// Drives event hits and cell reads into the coincidence matrix. Each read
// result is checked against a cycle-free model of the lower-triangle
// histogram. The run waits out the clearing pass after reset, covers edge
// channels and multiplicity overflow, and then sends random events under
// random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symmetric_coincidence_matrix_tb;

    import scm_pkg::*;

    localparam int CYCLE_LIMIT = 3 * CELL_TOTAL + 4000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                kind;
    logic [CH_W-1:0]     channel;
    logic [CH_W-1:0]     read_column;
    logic                last_hit;
    logic                out_valid;
    logic                out_stall;
    logic [COUNT_W-1:0]  cell_count;

    bit [COUNT_W-1:0]    pair_counts[int unsigned];
    int unsigned         event_channels[$];
    int unsigned         event_depth;
    bit [COUNT_W-1:0]    pending_counts[$];
    int unsigned         chan_pool[8];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    symmetric_coincidence_matrix u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .channel     (channel),
        .read_column (read_column),
        .last_hit    (last_hit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_count  (cell_count)
    );

    always #4 clk = ~clk;

    function automatic bit in_range(int unsigned ch);
        return (ch >= 1) && (ch <= CHANNELS - 2);
    endfunction

    function automatic int unsigned cell_index(int unsigned a, int unsigned b);
        int unsigned hi;
        int unsigned lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    function automatic bit [COUNT_W-1:0] lookup_cell(int unsigned row, int unsigned col);
        int unsigned idx;
        if (((row > col) ? row : col) >= CHANNELS)
        begin
            return '0;
        end
        idx = cell_index(row, col);
        return pair_counts.exists(idx) ? pair_counts[idx] : '0;
    endfunction

    function automatic void tally_hit(int unsigned ch, bit last);
        int unsigned idx;
        if (event_depth < MAX_MULT)
        begin
            if (in_range(ch))
            begin
                foreach (event_channels[k])
                begin
                    if (in_range(event_channels[k]))
                    begin
                        idx = cell_index(ch, event_channels[k]);
                        pair_counts[idx] = (pair_counts.exists(idx) ? pair_counts[idx] : '0) + 1;
                    end
                end
            end
            event_channels.push_back(ch);
            event_depth++;
        end
        if (last)
        begin
            event_channels.delete();
            event_depth = 0;
        end
    endfunction

    task automatic report_mismatch(string what, bit [COUNT_W-1:0] want, bit [COUNT_W-1:0] got);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        error_count++;
    endtask

    // Called at a falling edge; returns at a falling edge after the request is taken.
    task automatic send_request(kind_t k, int unsigned ch, int unsigned col, bit last);
        in_valid    <= 1'b1;
        kind        <= k;
        channel     <= ch[CH_W-1:0];
        read_column <= col[CH_W-1:0];
        last_hit    <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (k == KIND_READ)
        begin
            pending_counts.push_back(lookup_cell(ch, col));
        end
        else
        begin
            tally_hit(ch, last);
        end
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                report_mismatch("unexpected cell_count", '0, cell_count);
            end
            else
            begin
                if (cell_count !== pending_counts[0])
                begin
                    report_mismatch("cell_count", pending_counts[0], cell_count);
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    function automatic void refresh_pool();
        foreach (chan_pool[i])
        begin
            chan_pool[i] = $urandom_range(0, CHANNELS - 1);
        end
    endfunction

    function automatic int unsigned pick_channel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            return chan_pool[$urandom_range(0, 7)];
        end
        if (roll < 93)
        begin
            return $urandom_range(0, CHANNELS - 1);
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return CHANNELS - 2;
            default: return CHANNELS - 1;
        endcase
    endfunction

    function automatic int event_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            return $urandom_range(1, 10);
        end
        if (roll < 95)
        begin
            return $urandom_range(11, 30);
        end
        return $urandom_range(MAX_MULT - 2, MAX_MULT + 4);
    endfunction

    task automatic test_pairing_and_edges();
        send_request(KIND_READ, 0, 0, 1'b0);
        send_request(KIND_READ, CHANNELS - 1, CHANNELS - 1, 1'b1);
        send_request(KIND_READ, 0, CHANNELS - 1, 1'b0);
        send_request(KIND_READ, CHANNELS - 1, 0, 1'b1);
        send_request(KIND_HIT, 0, CHANNELS - 1, 1'b0);
        send_request(KIND_HIT, 1, 0, 1'b0);
        send_request(KIND_HIT, CHANNELS - 2, CHANNELS - 1, 1'b0);
        send_request(KIND_READ, CHANNELS - 2, 1, 1'b1);
        send_request(KIND_HIT, CHANNELS - 1, 0, 1'b0);
        send_request(KIND_HIT, 1, CHANNELS - 1, 1'b1);
        send_request(KIND_READ, CHANNELS - 2, 1, 1'b0);
        send_request(KIND_READ, 1, CHANNELS - 2, 1'b0);
        send_request(KIND_READ, 1, 1, 1'b0);
        send_request(KIND_READ, CHANNELS - 1, 1, 1'b0);
        send_request(KIND_READ, CHANNELS - 2, CHANNELS - 2, 1'b0);
        send_request(KIND_HIT, 2048, 2047, 1'b1);
        send_request(KIND_READ, 2048, 2048, 1'b0);
    endtask

    task automatic test_multiplicity_overflow();
        send_request(KIND_HIT, 0, 0, 1'b0);
        for (int i = 1; i < MAX_MULT; i++)
        begin
            send_request(KIND_HIT, 7, $urandom_range(0, CHANNELS - 1), 1'b0);
        end
        send_request(KIND_HIT, 7, 0, 1'b1);
        send_request(KIND_READ, 7, 7, 1'b0);
        send_request(KIND_HIT, 9, 0, 1'b1);
        send_request(KIND_READ, 9, 7, 1'b0);
    endtask

    task automatic test_random_events(int item_total);
        int sent_items;
        int len;
        int reads;
        int unsigned roll;
        sent_items = 0;
        while (sent_items < item_total)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                refresh_pool();
            end
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                len = event_length();
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_request(KIND_READ, pick_channel(), pick_channel(),
                                     1'($urandom_range(0, 1)));
                        sent_items++;
                    end
                    send_request(KIND_HIT, pick_channel(), $urandom_range(0, CHANNELS - 1),
                                 i == len - 1);
                end
                sent_items += len;
                reads = $urandom_range(1, 3);
                for (int i = 0; i < reads; i++)
                begin
                    send_request(KIND_READ, pick_channel(), pick_channel(),
                                 1'($urandom_range(0, 1)));
                end
                sent_items += reads;
            end
            else
            begin
                send_request(kind_t'($urandom_range(0, 1)), $urandom_range(0, CHANNELS - 1),
                             $urandom_range(0, CHANNELS - 1), $urandom_range(0, 3) == 0);
                sent_items++;
            end
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_HIT;
        channel       = '0;
        read_column   = '0;
        last_hit      = 1'b0;
        out_stall     = 1'b0;
        error_count   = 0;
        event_depth   = 0;
        send_idle_pct = 8;
        recv_idle_pct = 64;
        refresh_pool();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_pairing_and_edges();
        test_multiplicity_overflow();
        test_random_events(430);
        send_idle_pct = 64;
        recv_idle_pct = 8;
        test_random_events(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_events(430);

        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/scm_pkg.sv
design/scm_ram.sv
design/scm_outq.sv
design/scm_ctrl.sv
design/symmetric_coincidence_matrix.sv
sim/symmetric_coincidence_matrix_tb.sv
